// ----- hw/rtl/adhnp_pkg.sv -----
// Shared types, constants and helper functions for the ASCII number parser.
`default_nettype none

package adhnp_pkg;

   // Widths of the stream fields
   localparam int CHAR_WIDTH      = 8;
   localparam int NUMBER_WIDTH    = 32;
   localparam int EXT_WIDTH       = 64;
   localparam int DIGIT_WIDTH     = 4;
   localparam int POS_WIDTH       = 2;

   // Default accumulator width
   localparam int VALUE_WIDTH_DEF = 32;

   // Character codes
   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_WIDTH-1:0] CHAR_NINE  = 8'h39;
   localparam logic [CHAR_WIDTH-1:0] CHAR_X     = 8'h78;
   localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LA    = 8'h61;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LF    = 8'h66;
   localparam logic [CHAR_WIDTH-1:0] CHAR_UA    = 8'h41;
   localparam logic [CHAR_WIDTH-1:0] CHAR_UF    = 8'h46;

   // Position counter values
   localparam logic [POS_WIDTH-1:0] POS_FIRST  = 2'd0;
   localparam logic [POS_WIDTH-1:0] POS_SECOND = 2'd1;
   localparam logic [POS_WIDTH-1:0] POS_SAT    = 2'd3;

   // Status codes
   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_INVALID = 1'b1;

   // One input character with its end-of-token mark
   typedef struct packed {
      logic [CHAR_WIDTH-1:0] char_code;
      logic                  is_last;
   } item_type;

   // One parsed result
   typedef struct packed {
      logic [NUMBER_WIDTH-1:0] number;
      logic                    status;
   } result_type;

   // Decimal digit test
   function automatic logic is_dec_digit(input logic [CHAR_WIDTH-1:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

   // Hex digit test, either case
   function automatic logic is_hex_digit(input logic [CHAR_WIDTH-1:0] c);
      return ((c >= CHAR_ZERO) && (c <= CHAR_NINE)) ||
             ((c >= CHAR_LA) && (c <= CHAR_LF)) ||
             ((c >= CHAR_UA) && (c <= CHAR_UF));
   endfunction

   // Hex digit value; meaningless for non-digits
   function automatic logic [DIGIT_WIDTH-1:0] hex_value(input logic [CHAR_WIDTH-1:0] c);
      logic [CHAR_WIDTH-1:0] d;
      begin
         if ((c >= CHAR_LA) && (c <= CHAR_LF)) begin
            d = c - CHAR_LA + 8'd10;
         end else if ((c >= CHAR_UA) && (c <= CHAR_UF)) begin
            d = c - CHAR_UA + 8'd10;
         end else begin
            d = c - CHAR_ZERO;
         end
         return d[DIGIT_WIDTH-1:0];
      end
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/adhnp_in_stage.sv -----
// Input register stage: holds one character transaction until the parser takes it.
`default_nettype none

module adhnp_in_stage (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   input  wire  [adhnp_pkg::CHAR_WIDTH-1:0]    req_tdata,
   input  wire                                 req_tlast,
   input  wire                                 take,
   output logic                                item_valid,
   output adhnp_pkg::item_type                 item
);

   logic                valid_ff, valid_in;
   adhnp_pkg::item_type item_ff, item_in;
   logic                load;

   // Accept when empty or when the held item leaves this cycle
   assign req_tready = !valid_ff || take;
   assign load       = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (load) begin
         valid_in          = 1'b1;
         item_in.char_code = req_tdata;
         item_in.is_last   = req_tlast;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/adhnp_accum.sv -----
// Token state and digit accumulation; forms the result on the last character.
`default_nettype none

module adhnp_accum #(
   parameter int VALUE_WIDTH = adhnp_pkg::VALUE_WIDTH_DEF
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   step,
   input  adhnp_pkg::item_type   item,
   output adhnp_pkg::result_type result
);

   logic [VALUE_WIDTH-1:0]          acc_ff, acc_in, acc_upd;
   logic [adhnp_pkg::POS_WIDTH-1:0] pos_ff, pos_in;
   logic                            hex_ff, hex_in, hex_upd;
   logic                            fwz_ff, fwz_in, fwz_upd;
   logic                            neg_ff, neg_in, neg_upd;
   logic                            err_ff, err_in, err_upd;

   logic [VALUE_WIDTH-1:0]          dec_acc, hex_acc, dec_digit, hex_digit;
   logic [VALUE_WIDTH-1:0]          signed_val;
   logic [adhnp_pkg::EXT_WIDTH-1:0] ext_val;
   logic [adhnp_pkg::CHAR_WIDTH-1:0] c;
   logic                            dec_ok, is_minus, x_second;

   assign c         = item.char_code;
   assign dec_ok    = adhnp_pkg::is_dec_digit(c);
   assign is_minus  = (c == adhnp_pkg::CHAR_MINUS);
   assign x_second  = (pos_ff == adhnp_pkg::POS_SECOND) && fwz_ff && (c == adhnp_pkg::CHAR_X);

   // Times ten as two shifts and an add; times sixteen as a shift
   assign dec_digit = VALUE_WIDTH'(c - adhnp_pkg::CHAR_ZERO);
   assign hex_digit = VALUE_WIDTH'(adhnp_pkg::hex_value(c));
   assign dec_acc   = (acc_ff << 3) + (acc_ff << 1) + dec_digit;
   assign hex_acc   = (acc_ff << adhnp_pkg::DIGIT_WIDTH) + hex_digit;

   // Apply one character to the token state
   always_comb begin
      acc_upd = acc_ff;
      hex_upd = hex_ff;
      fwz_upd = fwz_ff;
      neg_upd = neg_ff;
      err_upd = err_ff;
      if (pos_ff == adhnp_pkg::POS_FIRST) begin
         fwz_upd = (c == adhnp_pkg::CHAR_ZERO);
      end
      if (x_second) begin
         // A bare "0x" token is an invalid decimal
         if (item.is_last) begin
            err_upd = 1'b1;
         end else begin
            hex_upd = 1'b1;
         end
      end else if (hex_ff) begin
         if (adhnp_pkg::is_hex_digit(c)) begin
            acc_upd = hex_acc;
         end else begin
            err_upd = 1'b1;
         end
      end else begin
         if (dec_ok) begin
            acc_upd = dec_acc;
         end else if (is_minus) begin
            acc_upd = '0;
            err_upd = 1'b0;
            neg_upd = 1'b1;
         end else begin
            err_upd = 1'b1;
         end
      end
   end

   // Advance the state, or clear it at the end of a token
   always_comb begin
      acc_in = acc_ff;
      pos_in = pos_ff;
      hex_in = hex_ff;
      fwz_in = fwz_ff;
      neg_in = neg_ff;
      err_in = err_ff;
      if (step) begin
         if (item.is_last) begin
            acc_in = '0;
            pos_in = adhnp_pkg::POS_FIRST;
            hex_in = 1'b0;
            fwz_in = 1'b0;
            neg_in = 1'b0;
            err_in = 1'b0;
         end else begin
            acc_in = acc_upd;
            pos_in = (pos_ff == adhnp_pkg::POS_SAT) ? pos_ff : pos_ff + 2'd1;
            hex_in = hex_upd;
            fwz_in = fwz_upd;
            neg_in = neg_upd;
            err_in = err_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         pos_ff <= adhnp_pkg::POS_FIRST;
         hex_ff <= 1'b0;
         fwz_ff <= 1'b0;
         neg_ff <= 1'b0;
         err_ff <= 1'b0;
      end else begin
         acc_ff <= acc_in;
         pos_ff <= pos_in;
         hex_ff <= hex_in;
         fwz_ff <= fwz_in;
         neg_ff <= neg_in;
         err_ff <= err_in;
      end
   end

   // Negate, sign-extend from the accumulator width, then cut to the output width
   assign signed_val = neg_upd ? (VALUE_WIDTH'(0) - acc_upd) : acc_upd;
   assign ext_val    = adhnp_pkg::EXT_WIDTH'($signed(signed_val));

   always_comb begin
      if (err_upd) begin
         result.number = '0;
         result.status = adhnp_pkg::STATUS_INVALID;
      end else begin
         result.number = ext_val[adhnp_pkg::NUMBER_WIDTH-1:0];
         result.status = adhnp_pkg::STATUS_OK;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/adhnp_out_stage.sv -----
// Result register stage: holds one parsed value until the consumer takes it.
`default_nettype none

module adhnp_out_stage (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  load,
   input  adhnp_pkg::result_type                result,
   output logic                                 free,
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   output logic [adhnp_pkg::NUMBER_WIDTH-1:0]   rsp_tdata,
   output logic [0:0]                           rsp_tuser
);

   logic                  valid_ff, valid_in;
   adhnp_pkg::result_type result_ff, result_in;

   // Room for a new result when empty or draining this cycle
   assign free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in  = valid_ff;
      result_in = result_ff;
      if (load) begin
         valid_in  = 1'b1;
         result_in = result;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      result_ff <= result_in;
   end

   assign rsp_tvalid   = valid_ff;
   assign rsp_tdata    = result_ff.number;
   assign rsp_tuser[0] = result_ff.status;

endmodule

`default_nettype wire

// ----- hw/rtl/ascii_dec_hex_number_parser.sv -----
// Top level of the streaming ASCII decimal/hex number parser.
//
//  channel | dir | tdata                  | tuser      | tlast
//  req_    | in  | [7:0] char_code        | -          | is_last
//  rsp_    | out | [31:0] number (signed) | [0] status | -
//
// One character is taken per cycle while no last character waits for room;
// a token's result goes through the input register, then the result register.
// Reset is synchronous and clears the token state and both valid flags.
// A stall on rsp_ holds only characters that end a token; other characters
// keep flowing into the accumulator while a result waits.
`default_nettype none

module ascii_dec_hex_number_parser #(
   parameter int VALUE_WIDTH = adhnp_pkg::VALUE_WIDTH_DEF
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   input  wire  [adhnp_pkg::CHAR_WIDTH-1:0]     req_tdata,   // [7:0] char_code
   input  wire                                  req_tlast,
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   output logic [adhnp_pkg::NUMBER_WIDTH-1:0]   rsp_tdata,   // [31:0] number
   output logic [0:0]                           rsp_tuser    // [0] status
);

   logic                  item_valid, step, out_free;
   adhnp_pkg::item_type   item;
   adhnp_pkg::result_type result;

   // Take the held character unless it ends a token and the result slot is full
   assign step = item_valid && (!item.is_last || out_free);

   adhnp_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .take       (step),
      .item_valid (item_valid),
      .item       (item)
   );

   adhnp_accum #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_accum (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (item),
      .result (result)
   );

   adhnp_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (step && item.is_last),
      .result     (result),
      .free       (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

// ----- tb/sv/ascii_dec_hex_number_parser_test.sv -----
// Self-checking stream testbench for the ASCII decimal/hex number parser.
`default_nettype none

module ascii_dec_hex_number_parser_test;

   localparam int CHAR_WIDTH      = adhnp_pkg::CHAR_WIDTH;
   localparam int NUMBER_WIDTH    = adhnp_pkg::NUMBER_WIDTH;
   localparam int POS_WIDTH       = adhnp_pkg::POS_WIDTH;
   localparam int DIGIT_WIDTH     = adhnp_pkg::DIGIT_WIDTH;

   localparam int NUM_TOKEN_CHARS = 1900;
   localparam int NUM_DIRECTED    = 22;
   localparam int HOLD_OFF_AFTER  = 500;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int IDLE_LIMIT      = 2000;
   localparam int DRAIN_CYCLES    = 8;

   // One row of the directed stimulus; typed rows carry their result
   typedef struct packed {
      logic [CHAR_WIDTH-1:0]   ch;
      logic                    last;
      logic                    typed;
      logic [NUMBER_WIDTH-1:0] num;
      logic                    st;
   } step_row_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [CHAR_WIDTH-1:0]   req_tdata = '0;     // [7:0] char_code
   logic                    req_tlast = 1'b0;   // is_last
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [NUMBER_WIDTH-1:0] rsp_tdata;          // [31:0] number
   logic [0:0]              rsp_tuser;          // [0] status

   // Parser state mirrored by the predictor
   logic [NUMBER_WIDTH-1:0] acc_q;
   logic [POS_WIDTH-1:0]    pos_cnt;
   logic                    in_hex;
   logic                    lead_zero;
   logic                    minus_seen;
   logic                    bad_char;

   adhnp_pkg::result_type parsed_q[$];
   step_row_type          directed_rows [NUM_DIRECTED];
   int                    chars_sent  = 0;
   int                    error_count = 0;
   int                    idle_count  = 0;
   bit                    no_gaps     = 1'b0;
   bit                    held_off    = 1'b0;

   ascii_dec_hex_number_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Return the token state to its reset values
   function automatic void clear_token();
      acc_q      = '0;
      pos_cnt    = adhnp_pkg::POS_FIRST;
      in_hex     = 1'b0;
      lead_zero  = 1'b0;
      minus_seen = 1'b0;
      bad_char   = 1'b0;
   endfunction

   // Decimal digits accumulate, a minus restarts the value, anything else is bad
   function automatic void take_decimal(input logic [CHAR_WIDTH-1:0] c);
      if (c >= adhnp_pkg::CHAR_ZERO && c <= adhnp_pkg::CHAR_NINE) begin
         acc_q = acc_q * 32'd10 + NUMBER_WIDTH'(c - adhnp_pkg::CHAR_ZERO);
      end else if (c == adhnp_pkg::CHAR_MINUS) begin
         acc_q      = '0;
         bad_char   = 1'b0;
         minus_seen = 1'b1;
      end else begin
         bad_char = 1'b1;
      end
   endfunction

   // Advance the token state by one character; a last character yields a result
   function automatic void parse_step(input logic [CHAR_WIDTH-1:0] c, input logic last,
                                      output logic done, output adhnp_pkg::result_type r);
      logic [DIGIT_WIDTH:0] nib;
      done = 1'b0;
      r    = '0;
      if (pos_cnt == adhnp_pkg::POS_FIRST) begin
         lead_zero = (c == adhnp_pkg::CHAR_ZERO);
         take_decimal(c);
      end else if (pos_cnt == adhnp_pkg::POS_SECOND && lead_zero &&
                   c == adhnp_pkg::CHAR_X) begin
         // a bare "0x" is still a decimal token, so the x is bad
         if (last) begin
            bad_char = 1'b1;
         end else begin
            in_hex = 1'b1;
         end
      end else if (in_hex) begin
         // top bit of nib flags a non-digit
         if (c >= adhnp_pkg::CHAR_ZERO && c <= adhnp_pkg::CHAR_NINE) begin
            nib = {1'b0, c[3:0]};
         end else if ((c >= adhnp_pkg::CHAR_LA && c <= adhnp_pkg::CHAR_LF) ||
                      (c >= adhnp_pkg::CHAR_UA && c <= adhnp_pkg::CHAR_UF)) begin
            nib = {1'b0, c[3:0] + 4'd9};
         end else begin
            nib = {1'b1, 4'h0};
         end
         if (nib[DIGIT_WIDTH]) begin
            bad_char = 1'b1;
         end else begin
            acc_q = {acc_q[NUMBER_WIDTH-DIGIT_WIDTH-1:0], nib[DIGIT_WIDTH-1:0]};
         end
      end else begin
         take_decimal(c);
      end
      if (pos_cnt != adhnp_pkg::POS_SAT) begin
         pos_cnt = pos_cnt + 1'b1;
      end
      if (last) begin
         done = 1'b1;
         if (bad_char) begin
            r.number = '0;
            r.status = adhnp_pkg::STATUS_INVALID;
         end else begin
            r.number = minus_seen ? (NUMBER_WIDTH'(0) - acc_q) : acc_q;
            r.status = adhnp_pkg::STATUS_OK;
         end
         clear_token();
      end
   endfunction

   // Mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Offer one character and wait for its transaction, then predict
   task automatic send_char(input logic [CHAR_WIDTH-1:0] c, input logic last,
                            input logic typed, input logic [NUMBER_WIDTH-1:0] tnum,
                            input logic tst);
      int                    gap;
      logic                  done;
      adhnp_pkg::result_type r;
      gap = no_gaps ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      chars_sent++;
      parse_step(c, last, done, r);
      if (done) begin
         if (typed) begin
            r.number = tnum;
            r.status = tst;
         end
         parsed_q.push_back(r);
      end
   endtask

   function automatic logic [CHAR_WIDTH-1:0] rand_dec_char();
      return adhnp_pkg::CHAR_ZERO + CHAR_WIDTH'($urandom_range(0, 9));
   endfunction

   function automatic logic [CHAR_WIDTH-1:0] rand_hex_char();
      int v;
      v = $urandom_range(0, 15);
      if (v < 10) return adhnp_pkg::CHAR_ZERO + CHAR_WIDTH'(v);
      return ($urandom_range(0, 1) ? adhnp_pkg::CHAR_UA : adhnp_pkg::CHAR_LA) +
             CHAR_WIDTH'(v - 10);
   endfunction

   // Build one token, mostly well formed, and send it
   task automatic send_random_token();
      logic [CHAR_WIDTH-1:0] tok[$];
      string                 s;
      int                    k;
      int                    n;
      k   = $urandom_range(0, 99);
      tok = {};
      s   = "";
      if (k < 35) begin
         // decimal, possibly signed, sometimes long enough to wrap
         if ($urandom_range(0, 2) == 0) tok.push_back(adhnp_pkg::CHAR_MINUS);
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 20) : $urandom_range(1, 10);
         repeat (n) begin
            if ($urandom_range(0, 29) == 0) tok.push_back(adhnp_pkg::CHAR_MINUS);
            else if ($urandom_range(0, 39) == 0) tok.push_back(CHAR_WIDTH'($urandom));
            else tok.push_back(rand_dec_char());
         end
      end else if (k < 70) begin
         // hex, digits of either case, now and then a bad character
         tok.push_back(adhnp_pkg::CHAR_ZERO);
         tok.push_back(adhnp_pkg::CHAR_X);
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 8);
         repeat (n) begin
            if ($urandom_range(0, 39) == 0) tok.push_back(adhnp_pkg::CHAR_MINUS);
            else if ($urandom_range(0, 39) == 0) tok.push_back(CHAR_WIDTH'($urandom));
            else tok.push_back(rand_hex_char());
         end
      end else if (k < 80) begin
         // boundary values
         case ($urandom_range(0, 7))
            0: s = "0xffffffff";
            1: s = "0x80000000";
            2: s = "0x7FFFFFFF";
            3: s = "4294967295";
            4: s = "2147483648";
            5: s = "-2147483648";
            6: s = "0x00000000";
            default: s = "4294967296";
         endcase
      end else if (k < 88) begin
         // short tokens around the hex prefix
         case ($urandom_range(0, 6))
            0: s = "0";
            1: s = "0x";
            2: s = "0X1";
            3: s = "-";
            4: s = "0-5";
            5: s = "x0";
            default: s = "0Xa-12";
         endcase
      end else begin
         // arbitrary bytes
         n = $urandom_range(1, 5);
         repeat (n) tok.push_back(CHAR_WIDTH'($urandom));
      end
      for (int i = 0; i < s.len(); i++) begin
         tok.push_back(s[i]);
      end
      no_gaps = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < tok.size(); i++) begin
         send_char(tok[i], i == tok.size() - 1, 1'b0, '0, adhnp_pkg::STATUS_OK);
      end
   endtask

   // Stimulus: reset, directed rows, random tokens, drain
   initial begin
      directed_rows = '{
         '{"0",   1'b1, 1'b1, 32'd0,   adhnp_pkg::STATUS_OK},       // lone zero
         '{"0",   1'b0, 1'b0, 32'd0,   adhnp_pkg::STATUS_OK},       // exactly 0x
         '{"x",   1'b1, 1'b1, 32'd0,   adhnp_pkg::STATUS_INVALID},
         '{"-",   1'b1, 1'b1, 32'd0,   adhnp_pkg::STATUS_OK},       // lone minus
         '{"0",   1'b0, 1'b0, 32'd0,   adhnp_pkg::STATUS_OK},       // hex, mixed case
         '{"x",   1'b0, 1'b0, 32'd0,   adhnp_pkg::STATUS_OK},
         '{"F",   1'b0, 1'b0, 32'd0,   adhnp_pkg::STATUS_OK},
         '{"f",   1'b1, 1'b1, 32'd255, adhnp_pkg::STATUS_OK},
         '{"0",   1'b0, 1'b0, 32'd0,   adhnp_pkg::STATUS_OK},       // minus inside hex
         '{"x",   1'b0, 1'b0, 32'd0,   adhnp_pkg::STATUS_OK},
         '{"-",   1'b1, 1'b1, 32'd0,   adhnp_pkg::STATUS_INVALID},
         '{"0",   1'b0, 1'b0, 32'd0,   adhnp_pkg::STATUS_OK},       // uppercase X prefix
         '{"X",   1'b0, 1'b0, 32'd0,   adhnp_pkg::STATUS_OK},
         '{"1",   1'b1, 1'b1, 32'd0,   adhnp_pkg::STATUS_INVALID},
         '{8'hFF, 1'b1, 1'b1, 32'd0,   adhnp_pkg::STATUS_INVALID},  // top byte
         '{8'h00, 1'b1, 1'b1, 32'd0,   adhnp_pkg::STATUS_INVALID},  // bottom byte
         '{"x",   1'b0, 1'b0, 32'd0,   adhnp_pkg::STATUS_OK},       // minus clears an error
         '{"-",   1'b0, 1'b0, 32'd0,   adhnp_pkg::STATUS_OK},
         '{"5",   1'b1, 1'b0, 32'd0,   adhnp_pkg::STATUS_OK},
         '{"9",   1'b1, 1'b1, 32'd9,   adhnp_pkg::STATUS_OK},
         '{"8",   1'b0, 1'b0, 32'd0,   adhnp_pkg::STATUS_OK},       // trailing minus
         '{"-",   1'b1, 1'b0, 32'd0,   adhnp_pkg::STATUS_OK}
      };
      clear_token();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_rows[i]) begin
         send_char(directed_rows[i].ch, directed_rows[i].last, directed_rows[i].typed,
                   directed_rows[i].num, directed_rows[i].st);
      end
      while (chars_sent < NUM_TOKEN_CHARS) begin
         send_random_token();
      end
      req_tvalid <= 1'b0;
      while (parsed_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Result side ready: bursts, random stalls and one long hold-off
   initial begin
      int mode;
      @(negedge reset);
      forever begin
         if (!held_off && chars_sent >= HOLD_OFF_AFTER) begin
            held_off = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            mode = $urandom_range(0, 9);
            if (mode < 2) begin
               rsp_tready <= 1'b1;
               repeat ($urandom_range(20, 80)) @(posedge clock);
            end else if (mode < 9) begin
               rsp_tready <= ($urandom_range(0, 9) < 7);
               repeat ($urandom_range(1, 3)) @(posedge clock);
            end else begin
               rsp_tready <= 1'b0;
               repeat (pick_gap() + 1) @(posedge clock);
            end
         end
      end
   end

   // Check each result transaction against the oldest prediction
   always @(posedge clock) begin
      adhnp_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (parsed_q.size() == 0) begin
            $error("unexpected result: number %h status %0d", rsp_tdata, rsp_tuser[0]);
            error_count++;
         end else begin
            want = parsed_q.pop_front();
            if (rsp_tdata !== want.number) begin
               $error("number mismatch: expected %h, got %h", want.number, rsp_tdata);
               error_count++;
            end
            if (rsp_tuser[0] !== want.status) begin
               $error("status mismatch: expected %0d, got %0d", want.status, rsp_tuser[0]);
               error_count++;
            end
         end
      end
   end

   // Watchdog: end the run when no transaction moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_count <= 0;
      end else if (idle_count >= IDLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_count <= idle_count + 1;
      end
   end

endmodule

`default_nettype wire

// ----- ascii_dec_hex_number_parser.f -----
hw/rtl/adhnp_pkg.sv
hw/rtl/adhnp_in_stage.sv
hw/rtl/adhnp_accum.sv
hw/rtl/adhnp_out_stage.sv
hw/rtl/ascii_dec_hex_number_parser.sv
tb/sv/ascii_dec_hex_number_parser_test.sv
